// ----- hw/rtl/mlp_pkg.sv -----
// Package for the pixel classifier: weight constants, types and the sigmoid function.
// No dependencies; used by every module of the block.
package mlp_pkg;

  localparam int NumHidden = 7;
  localparam int NumOut = 2;
  localparam int ChanW = 8;
  localparam int ScoreW = 16;
  localparam int HidSumW = 26;
  localparam int OutSumW = 40;

  typedef logic signed [17:0] weight_t;
  typedef logic [ScoreW-1:0] score_t;
  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    score_t [NumHidden-1:0] hid;
  } hidden_t;

  localparam weight_t HidW [NumHidden][4] = '{
    '{18'sd18634, -18'sd1138, 18'sd3395, 18'sd1860},
    '{18'sd26718, 18'sd17874, -18'sd17270, 18'sd4146},
    '{18'sd28531, -18'sd21524, 18'sd10033, 18'sd2509},
    '{-18'sd982, 18'sd13704, -18'sd14445, -18'sd4620},
    '{18'sd13428, -18'sd11299, 18'sd10693, 18'sd214},
    '{18'sd33892, 18'sd20822, -18'sd22631, 18'sd5097},
    '{18'sd29076, -18'sd9167, 18'sd3134, 18'sd1904}
  };

  localparam weight_t OutW [NumOut][8] = '{
    '{18'sd104, -18'sd11487, 18'sd4029, -18'sd4922, 18'sd4626, -18'sd16758, -18'sd990,
      18'sd7686},
    '{-18'sd1917, 18'sd2508, -18'sd12167, 18'sd6385, -18'sd5202, 18'sd1705, -18'sd8040,
      18'sd7496}
  };

  function automatic score_t sigmoid(input logic signed [HidSumW-1:0] x);
    logic [HidSumW-1:0] a;
    logic [24:0] y;
    begin
      a = x[HidSumW-1] ? HidSumW'(-x) : HidSumW'(x);
      if (a >= HidSumW'(20480)) y = 25'd65536;
      else if (a >= HidSumW'(9728)) y = 25'(a >> 1) + 25'd55296;
      else if (a >= HidSumW'(4096)) y = 25'(a) * 25'd2 + 25'd40960;
      else y = 25'(a) * 25'd4 + 25'd32768;
      if (x[HidSumW-1]) y = 25'd65536 - y;
      sigmoid = (y > 25'd65535) ? 16'hFFFF : y[15:0];
    end
  endfunction

endpackage

// ----- hw/rtl/mlp_front.sv -----
// Front stage: accepts a pixel and computes the seven hidden activations.
// Depends on mlp_pkg.
module mlp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  mlp_pkg::pixel_t pix_i,
  output logic            valid_o,
  input  logic            stall_i,
  output mlp_pkg::hidden_t hid_o
);
  import mlp_pkg::*;

  logic valid_q;
  hidden_t hid_q, hid_d;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    logic signed [HidSumW-1:0] s;
    for (int n = 0; n < NumHidden; n++) begin
      s = $signed({1'b0, pix_i.red}) * HidSumW'(HidW[n][0])
        + $signed({1'b0, pix_i.green}) * HidSumW'(HidW[n][1])
        + $signed({1'b0, pix_i.blue}) * HidSumW'(HidW[n][2])
        + HidSumW'(HidW[n][3]);
      hid_d.hid[n] = sigmoid(s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      hid_q <= hid_d;
    end
  end

  assign valid_o = valid_q;
  assign hid_o = hid_q;
endmodule

// ----- hw/rtl/mlp_queue.sv -----
// Two-entry queue between the hidden layer and the output layer.
// Depends on mlp_pkg.
module mlp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  mlp_pkg::hidden_t data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output mlp_pkg::hidden_t data_o
);
  import mlp_pkg::*;

  hidden_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push = valid_i && !stall_o;
  assign pop = valid_o && !stall_i;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_q == rd_q)) else $error("empty queue pointers differ");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (wr_q == rd_q)) else $error("full queue pointers differ");
endmodule

// ----- hw/rtl/mlp_back.sv -----
// Back stage: output neurons, multiply stage then sum and sigmoid stage.
// Depends on mlp_pkg.
module mlp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  mlp_pkg::hidden_t hid_i,
  output logic             valid_o,
  input  logic             stall_i,
  output mlp_pkg::score_t  first_o,
  output mlp_pkg::score_t  second_o
);
  import mlp_pkg::*;

  logic v1_q, v2_q;
  logic signed [34:0] prod_q [NumOut][NumHidden];
  score_t sc_q [NumOut];
  logic adv2, adv1;
  score_t sc_d [NumOut];

  assign adv2 = !(v2_q && stall_i);
  assign adv1 = adv2 || !v1_q;
  assign stall_o = !adv1;

  always_comb begin
    logic signed [OutSumW-1:0] s;
    for (int k = 0; k < NumOut; k++) begin
      s = OutSumW'(OutW[k][7]) <<< 16;
      for (int n = 0; n < NumHidden; n++) s = s + OutSumW'(prod_q[k][n]);
      sc_d[k] = sigmoid(HidSumW'(s >>> 16));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      for (int k = 0; k < NumOut; k++)
        for (int n = 0; n < NumHidden; n++)
          prod_q[k][n] <= $signed({1'b0, hid_i.hid[n]}) * OutW[k][n];
    end
    if (adv2 && v1_q) begin
      sc_q <= sc_d;
    end
  end

  assign valid_o = v2_q;
  assign first_o = sc_q[0];
  assign second_o = sc_q[1];
endmodule

// ----- hw/rtl/mlp_pixel_classifier_unit.sv -----
// Top level of the pixel classifier: front stage, queue and back stage.
// Depends on mlp_pkg, mlp_front, mlp_queue and mlp_back.
//
//  Channel  Handshake            Payload
//  pixel    valid_i / stall_o    red_i, green_i, blue_i
//  score    valid_o / stall_i    score_first_o, score_second_o
//
// One pixel is accepted per cycle while stall_o is low; a result passes through the hidden
// register, the queue entry, the product register and the score register in that order.
// Reset is asynchronous and active low and clears the valid bits and the queue pointers and count.
// The two-entry queue lets the front keep accepting while the score side stalls, until the queue is full.
module mlp_pixel_classifier_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  mlp_pkg::chan_t       red_i,
  input  mlp_pkg::chan_t       green_i,
  input  mlp_pkg::chan_t       blue_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output mlp_pkg::score_t      score_first_o,
  output mlp_pkg::score_t      score_second_o
);
  import mlp_pkg::*;

  pixel_t pix;
  hidden_t f_hid, q_hid;
  logic f_valid, f_stall, q_valid, q_stall;

  assign pix = '{red: red_i, green: green_i, blue: blue_i};

  mlp_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .pix_i(pix),
    .valid_o(f_valid), .stall_i(f_stall), .hid_o(f_hid)
  );

  mlp_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_valid), .stall_o(f_stall), .data_i(f_hid),
    .valid_o(q_valid), .stall_i(q_stall), .data_o(q_hid)
  );

  mlp_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .stall_o(q_stall), .hid_i(q_hid),
    .valid_o, .stall_i, .first_o(score_first_o), .second_o(score_second_o)
  );
endmodule
